@@ rtl/core/spim3_pkg.sv @@
// ----------------------------------------------------------------------------
// spim3_pkg: shared types and constants for the SPI mode 3 master
// Phase codes, register indexes, status codes, pin positions and the
// structs that pass state, configuration, tick and result between modules.
// ----------------------------------------------------------------------------
package spim3_pkg;

  // Receive slot count; the slot index wraps at this value
  localparam int RX_SLOTS = 32;
  localparam int SLOT_W   = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
  localparam int RX_SLOT_OUT_W = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_MSB_FIRST   = 3'd0;
  localparam logic [2:0] REG_CS_USED     = 3'd1;
  localparam logic [2:0] REG_MOSI_USED   = 3'd2;
  localparam logic [2:0] REG_MISO_USED   = 3'd3;
  localparam logic [2:0] REG_DELAY_TICKS = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_READ_NO_MISO = 2'd1;
  localparam logic [1:0] ST_NO_DATA_LINE = 2'd2;

  // Bit positions in the pin level vector
  localparam int PIN_CS   = 0;
  localparam int PIN_SCK  = 1;
  localparam int PIN_MOSI = 2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CS_START  = 3'd1,
    PH_BIT_LOW   = 3'd2,
    PH_BIT_HIGH  = 3'd3,
    PH_WAIT_BYTE = 3'd4,
    PH_CS_END    = 3'd5
  } phase_t;

  typedef struct packed {
    logic       msb_first;
    logic       cs_used;
    logic       mosi_used;
    logic       miso_used;
    logic [7:0] delay_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [7:0]        delay_left;
    logic [2:0]        bit_index;
    logic [7:0]        tx_shift;
    logic [7:0]        rx_shift;
    logic [SLOT_W-1:0] slot_count;
    logic              read_mode;
    logic              final_pending;
    logic [2:0]        pins;
  } seq_state_t;

  typedef struct packed {
    logic       byte_valid;
    logic       func;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       miso_level;
  } tick_t;

  typedef struct packed {
    logic                     cs_level;
    logic                     sck_level;
    logic                     mosi_level;
    logic                     byte_taken;
    logic                     rx_valid;
    logic [7:0]               rx_byte;
    logic [RX_SLOT_OUT_W-1:0] rx_slot;
    logic                     busy_res;
    logic [1:0]               status;
  } result_t;

endpackage

@@ rtl/core/spi_master_mode3_bitbang_unit.sv @@
// Output: a tick's result is registered and is on the master side in the
//   cycle after its transaction on the slave side.
// Throughput: one tick per cycle while m_tready is high; the sequencer
//   state moves in the same cycle as the tick is taken; output frees on m_tready.
// Reset (rst, synchronous): sequencer idle, pins high, registers at defaults.
// ----------------------------------------------------------------------------
// spi_master_mode3_bitbang_unit: SPI mode 3 master, one tick per transaction
// Holds the configuration registers, the sequencer state and the result
// register; the per-tick logic sits in spim3_step.
// ----------------------------------------------------------------------------
module spi_master_mode3_bitbang_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Tick input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_valid, tx_byte[7:0], miso_level, zero pad
  input  logic        s_tlast,   // last_byte
  input  logic        s_tuser,   // func
  // Result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cs_level, sck_level, mosi_level, byte_taken,
                                 // rx_valid, rx_byte[7:0], rx_slot[4:0],
                                 // busy_res, zero pad
  output logic [1:0]  m_tuser    // status
);

  spim3_pkg::cfg_t       cfg;
  spim3_pkg::seq_state_t st;
  spim3_pkg::seq_state_t st_next;
  spim3_pkg::tick_t      tick;
  spim3_pkg::result_t    res;
  spim3_pkg::result_t    res_q;
  logic                  s_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;

  // Unpack the tick
  assign tick.byte_valid = s_tdata[0];
  assign tick.tx_byte    = s_tdata[8:1];
  assign tick.miso_level = s_tdata[9];
  assign tick.last_byte  = s_tlast;
  assign tick.func       = s_tuser;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.msb_first   <= 1'b1;
      cfg.cs_used     <= 1'b1;
      cfg.mosi_used   <= 1'b1;
      cfg.miso_used   <= 1'b1;
      cfg.delay_ticks <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spim3_pkg::REG_MSB_FIRST:   cfg.msb_first   <= cfg_data[0];
        spim3_pkg::REG_CS_USED:     cfg.cs_used     <= cfg_data[0];
        spim3_pkg::REG_MOSI_USED:   cfg.mosi_used   <= cfg_data[0];
        spim3_pkg::REG_MISO_USED:   cfg.miso_used   <= cfg_data[0];
        spim3_pkg::REG_DELAY_TICKS: cfg.delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  spim3_step u_step (
    .st      (st),
    .cfg     (cfg),
    .tick    (tick),
    .st_next (st_next),
    .res     (res)
  );

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= spim3_pkg::PH_IDLE;
      st.delay_left    <= 8'd0;
      st.bit_index     <= 3'd0;
      st.tx_shift      <= 8'd0;
      st.rx_shift      <= 8'd0;
      st.slot_count    <= '0;
      st.read_mode     <= 1'b0;
      st.final_pending <= 1'b0;
      st.pins          <= 3'b111;
    end else if (s_fire) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = {5'd0, res_q.busy_res, res_q.rx_slot, res_q.rx_byte,
                    res_q.rx_valid, res_q.byte_taken, res_q.mosi_level,
                    res_q.sck_level, res_q.cs_level};
  assign m_tuser = res_q.status;

`ifndef SYNTH
  // A received byte is reported on the SCK rise
  a_rx_on_rise: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_q.rx_valid) |-> res_q.sck_level)
    else $error("rx byte reported without SCK high");

  // Without a received byte the byte and slot fields are zero
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_q.rx_valid) |-> (res_q.rx_byte == 8'd0 && res_q.rx_slot == '0))
    else $error("rx fields not zero without rx_valid");

  // A refused request is consumed and starts no frame
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_q.status != spim3_pkg::ST_OK)
      |-> (res_q.byte_taken && !res_q.busy_res))
    else $error("refused request not consumed or started a frame");

  // Outside a frame chip select and SCK are high
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_q.busy_res) |-> (res_q.cs_level && res_q.sck_level))
    else $error("idle pins not high");

  // State only moves on an accepted tick
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s_fire |=> $stable(st))
    else $error("sequencer state changed without a tick");
`endif

endmodule

@@ rtl/core/spim3_step.sv @@
// ----------------------------------------------------------------------------
// spim3_step: one tick of the SPI mode 3 bit sequencer
// Takes the current sequencer state, the live configuration and one tick,
// and gives the next state and the result of that tick.
// ----------------------------------------------------------------------------
module spim3_step (
  input  spim3_pkg::seq_state_t st,
  input  spim3_pkg::cfg_t       cfg,
  input  spim3_pkg::tick_t      tick,
  output spim3_pkg::seq_state_t st_next,
  output spim3_pkg::result_t    res
);

  logic       do_idle;
  logic       do_load;
  logic       do_fall;
  logic       do_rise;
  logic       do_done;
  logic       miso_bit;
  logic [2:0] sh;
  logic [7:0] hold;

  // Hold length after an edge; a zero delay acts as one
  assign hold = (cfg.delay_ticks == 8'd0) ? 8'd0 : cfg.delay_ticks - 8'd1;

  always_comb begin
    st_next  = st;
    res      = '0;
    do_idle  = 1'b0;
    do_load  = 1'b0;
    do_fall  = 1'b0;
    do_rise  = 1'b0;
    do_done  = 1'b0;
    miso_bit = cfg.miso_used & tick.miso_level;
    sh       = 3'd0;

    // Dispatch on phase and hold counter
    case (st.phase)
      spim3_pkg::PH_IDLE: begin
        do_idle = 1'b1;
      end
      spim3_pkg::PH_WAIT_BYTE: begin
        do_load = tick.byte_valid;
      end
      default: begin
        if (st.delay_left != 8'd0) begin
          st_next.delay_left = st.delay_left - 8'd1;
        end else if (st.phase == spim3_pkg::PH_CS_START) begin
          do_fall = 1'b1;
        end else if (st.phase == spim3_pkg::PH_BIT_LOW) begin
          do_rise = 1'b1;
        end else if (st.phase == spim3_pkg::PH_BIT_HIGH) begin
          if (st.bit_index != 3'd7) begin
            st_next.bit_index = st.bit_index + 3'd1;
            do_fall = 1'b1;
          end else begin
            do_done = 1'b1;
          end
        end else begin
          do_idle = 1'b1;
        end
      end
    endcase

    // SCK rise: sample MISO, report the byte after the eighth bit
    if (do_rise) begin
      if (cfg.msb_first) begin
        st_next.rx_shift = {st.rx_shift[6:0], miso_bit};
      end else begin
        st_next.rx_shift = {miso_bit, st.rx_shift[7:1]};
      end
      st_next.pins[spim3_pkg::PIN_SCK] = 1'b1;
      st_next.phase      = spim3_pkg::PH_BIT_HIGH;
      st_next.delay_left = hold;
      if (st.bit_index == 3'd7) begin
        res.rx_valid = 1'b1;
        res.rx_byte  = st_next.rx_shift;
        res.rx_slot  = spim3_pkg::RX_SLOT_OUT_W'(st.slot_count);
        if (st.slot_count == spim3_pkg::SLOT_W'(spim3_pkg::RX_SLOTS - 1)) begin
          st_next.slot_count = '0;
        end else begin
          st_next.slot_count = st.slot_count + spim3_pkg::SLOT_W'(1);
        end
      end
    end

    // Byte finished: next byte, wait, or close the frame
    if (do_done) begin
      if (!st.final_pending) begin
        if (tick.byte_valid) begin
          do_load = 1'b1;
        end else begin
          st_next.phase = spim3_pkg::PH_WAIT_BYTE;
        end
      end else begin
        st_next.pins[spim3_pkg::PIN_CS] = 1'b1;
        if (cfg.cs_used) begin
          st_next.phase      = spim3_pkg::PH_CS_END;
          st_next.delay_left = hold;
        end else begin
          do_idle = 1'b1;
        end
      end
    end

    // Idle: accept or refuse a request, start a frame
    if (do_idle) begin
      st_next.phase = spim3_pkg::PH_IDLE;
      if (tick.byte_valid) begin
        if (!cfg.mosi_used && !cfg.miso_used) begin
          res.byte_taken = 1'b1;
          res.status     = spim3_pkg::ST_NO_DATA_LINE;
        end else if (tick.func && !cfg.miso_used) begin
          res.byte_taken = 1'b1;
          res.status     = spim3_pkg::ST_READ_NO_MISO;
        end else begin
          st_next.read_mode  = tick.func;
          st_next.slot_count = '0;
          if (cfg.cs_used) begin
            st_next.tx_shift      = tick.tx_byte;
            st_next.final_pending = tick.last_byte;
            st_next.rx_shift      = 8'd0;
            st_next.bit_index     = 3'd0;
            res.byte_taken        = 1'b1;
            st_next.pins[spim3_pkg::PIN_CS] = 1'b0;
            st_next.phase         = spim3_pkg::PH_CS_START;
            st_next.delay_left    = hold;
          end else begin
            do_load = 1'b1;
          end
        end
      end
    end

    // Load a new byte into the shifter
    if (do_load) begin
      st_next.tx_shift      = tick.tx_byte;
      st_next.final_pending = tick.last_byte;
      st_next.rx_shift      = 8'd0;
      st_next.bit_index     = 3'd0;
      res.byte_taken        = 1'b1;
      do_fall               = 1'b1;
    end

    // SCK fall: drive MOSI unless reading or no MOSI line
    if (do_fall) begin
      sh = cfg.msb_first ? (3'd7 - st_next.bit_index) : st_next.bit_index;
      if (!st_next.read_mode && cfg.mosi_used) begin
        st_next.pins[spim3_pkg::PIN_MOSI] = st_next.tx_shift[sh];
      end
      st_next.pins[spim3_pkg::PIN_SCK] = 1'b0;
      st_next.phase      = spim3_pkg::PH_BIT_LOW;
      st_next.delay_left = hold;
    end

    // Pin levels and busy flag after this tick
    res.cs_level   = st_next.pins[spim3_pkg::PIN_CS];
    res.sck_level  = st_next.pins[spim3_pkg::PIN_SCK];
    res.mosi_level = st_next.pins[spim3_pkg::PIN_MOSI];
    res.busy_res   = (st_next.phase != spim3_pkg::PH_IDLE);
  end

endmodule

@@ tb/sv/tb_spi_master_mode3_bitbang_unit.sv @@
// ----------------------------------------------------------------------------
// tb_spi_master_mode3_bitbang_unit: self-checking bench for the SPI mode 3 master
// A queue of ticks and register writes feeds a clocked driver. The driver
// predicts the pins and receive report of every accepted tick into a queue
// of due results. A clocked monitor compares each returned result with the
// oldest due one, field by field. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_spi_master_mode3_bitbang_unit;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CFG   = 2'd1,
    OP_DRAIN = 2'd2
  } stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    spim3_pkg::tick_t  tk;
    logic [2:0]        idx;
    logic [7:0]        val;
    int                gap;
  } stim_op_t;

  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = spim3_pkg::REG_MSB_FIRST;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  spi_master_mode3_bitbang_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Stimulus and bookkeeping
  stim_op_t           stim_q[$];
  spim3_pkg::result_t tick_results_due[$];
  int                 cur_gap_max = 0;
  int                 sent_count = 0;
  int                 got_count = 0;
  int                 fail_count = 0;
  logic               stim_done = 1'b0;

  // Shadow registers
  logic       cfg_msb = 1'b1;
  logic       cfg_cs = 1'b1;
  logic       mosi_line = 1'b1;
  logic       miso_line = 1'b1;
  logic [7:0] cfg_delay = 8'd1;

  // Shadow sequencer state
  spim3_pkg::phase_t  seq_phase = spim3_pkg::PH_IDLE;
  logic [7:0]         hold_left = 8'd0;
  logic [2:0]         bit_pos = 3'd0;
  logic [7:0]         tx_bits = 8'd0;
  logic [7:0]         rx_bits = 8'd0;
  int                 frame_slot = 0;
  logic               read_only = 1'b0;
  logic               last_pending = 1'b0;
  logic [2:0]         pin_lv = 3'b111;
  spim3_pkg::result_t tick_res;

  // Half-bit hold length; a zero delay behaves as one tick
  function automatic logic [7:0] hold_cycles();
    return (cfg_delay == 8'd0) ? 8'd0 : cfg_delay - 8'd1;
  endfunction

  // Drive MOSI for the current bit and drop SCK
  function automatic void sck_fall();
    int sh;
    if (!read_only && mosi_line) begin
      sh = cfg_msb ? 7 - int'(bit_pos) : int'(bit_pos);
      pin_lv[spim3_pkg::PIN_MOSI] = tx_bits[sh];
    end
    pin_lv[spim3_pkg::PIN_SCK] = 1'b0;
    seq_phase = spim3_pkg::PH_BIT_LOW;
    hold_left = hold_cycles();
  endfunction

  function automatic void load_byte(input spim3_pkg::tick_t t);
    tx_bits = t.tx_byte;
    last_pending = t.last_byte;
    rx_bits = 8'd0;
    bit_pos = 3'd0;
    tick_res.byte_taken = 1'b1;
    sck_fall();
  endfunction

  // Idle handling: refuse impossible requests or open a frame
  function automatic void idle_tick(input spim3_pkg::tick_t t);
    seq_phase = spim3_pkg::PH_IDLE;
    if (t.byte_valid) begin
      if (!mosi_line && !miso_line) begin
        tick_res.byte_taken = 1'b1;
        tick_res.status = spim3_pkg::ST_NO_DATA_LINE;
      end else if (t.func && !miso_line) begin
        tick_res.byte_taken = 1'b1;
        tick_res.status = spim3_pkg::ST_READ_NO_MISO;
      end else begin
        read_only = t.func;
        frame_slot = 0;
        if (cfg_cs) begin
          tx_bits = t.tx_byte;
          last_pending = t.last_byte;
          rx_bits = 8'd0;
          bit_pos = 3'd0;
          tick_res.byte_taken = 1'b1;
          pin_lv[spim3_pkg::PIN_CS] = 1'b0;
          seq_phase = spim3_pkg::PH_CS_START;
          hold_left = hold_cycles();
        end else begin
          load_byte(t);
        end
      end
    end
  endfunction

  // Advance the shadow sequencer by one tick and queue its result
  function automatic void spim3_predict_tick(input spim3_pkg::tick_t t);
    logic b;
    tick_res = '0;
    if (seq_phase == spim3_pkg::PH_IDLE) begin
      idle_tick(t);
    end else if (seq_phase == spim3_pkg::PH_WAIT_BYTE) begin
      if (t.byte_valid) load_byte(t);
    end else if (hold_left > 8'd0) begin
      hold_left = hold_left - 8'd1;
    end else if (seq_phase == spim3_pkg::PH_CS_START) begin
      sck_fall();
    end else if (seq_phase == spim3_pkg::PH_BIT_LOW) begin
      // Rising edge samples MISO
      b = miso_line ? t.miso_level : 1'b0;
      rx_bits = cfg_msb ? {rx_bits[6:0], b} : {b, rx_bits[7:1]};
      pin_lv[spim3_pkg::PIN_SCK] = 1'b1;
      seq_phase = spim3_pkg::PH_BIT_HIGH;
      hold_left = hold_cycles();
      if (bit_pos == 3'd7) begin
        tick_res.rx_valid = 1'b1;
        tick_res.rx_byte = rx_bits;
        tick_res.rx_slot = frame_slot[spim3_pkg::RX_SLOT_OUT_W-1:0];
        frame_slot = (frame_slot + 1 >= spim3_pkg::RX_SLOTS) ? 0 : frame_slot + 1;
      end
    end else if (seq_phase == spim3_pkg::PH_BIT_HIGH) begin
      if (bit_pos != 3'd7) begin
        bit_pos = bit_pos + 3'd1;
        sck_fall();
      end else if (!last_pending) begin
        if (t.byte_valid) load_byte(t);
        else seq_phase = spim3_pkg::PH_WAIT_BYTE;
      end else begin
        pin_lv[spim3_pkg::PIN_CS] = 1'b1;
        if (cfg_cs) begin
          seq_phase = spim3_pkg::PH_CS_END;
          hold_left = hold_cycles();
        end else begin
          idle_tick(t);
        end
      end
    end else begin
      idle_tick(t);
    end
    tick_res.cs_level = pin_lv[spim3_pkg::PIN_CS];
    tick_res.sck_level = pin_lv[spim3_pkg::PIN_SCK];
    tick_res.mosi_level = pin_lv[spim3_pkg::PIN_MOSI];
    tick_res.busy_res = (seq_phase != spim3_pkg::PH_IDLE);
    tick_results_due.push_back(tick_res);
  endfunction

  function automatic void shadow_write(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      spim3_pkg::REG_MSB_FIRST:   cfg_msb = val[0];
      spim3_pkg::REG_CS_USED:     cfg_cs = val[0];
      spim3_pkg::REG_MOSI_USED:   mosi_line = val[0];
      spim3_pkg::REG_MISO_USED:   miso_line = val[0];
      spim3_pkg::REG_DELAY_TICKS: cfg_delay = val;
      default: ;
    endcase
  endfunction

  // Driver: ticks, register writes and drain points from the stimulus queue
  spim3_pkg::tick_t cur_tick;
  int               hold_off = 0;
  logic             tick_fire, cfg_fire, settled, next_tv, next_cv;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      hold_off = 0;
    end else begin
      tick_fire = s_tvalid && s_tready;
      cfg_fire = cfg_valid && cfg_ready;
      if (tick_fire) begin
        spim3_predict_tick(cur_tick);
        sent_count <= sent_count + 1;
      end
      if (cfg_fire) shadow_write(cfg_index, cfg_data);
      if (!((s_tvalid && !tick_fire) || (cfg_valid && !cfg_fire))) begin
        next_tv = 1'b0;
        next_cv = 1'b0;
        settled = !tick_fire && (sent_count == got_count);
        if (hold_off > 0) begin
          hold_off--;
        end else if (stim_q.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          case (stim_q[0].kind)
            OP_TICK: begin
              cur_tick = stim_q[0].tk;
              hold_off = stim_q[0].gap;
              stim_q.pop_front();
              s_tdata <= {6'd0, cur_tick.miso_level, cur_tick.tx_byte, cur_tick.byte_valid};
              s_tlast <= cur_tick.last_byte;
              s_tuser <= cur_tick.func;
              next_tv = 1'b1;
            end
            OP_CFG: begin
              if (settled) begin
                cfg_index <= stim_q[0].idx;
                cfg_data <= stim_q[0].val;
                stim_q.pop_front();
                next_cv = 1'b1;
              end
            end
            default: begin
              if (settled) stim_q.pop_front();
            end
          endcase
        end
        s_tvalid <= next_tv;
        cfg_valid <= next_cv;
      end
    end
  end

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, seen);
    end
  endtask

  // Monitor: result transactions checked against the oldest due result
  int                 stall_left = 0;
  spim3_pkg::result_t due;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_count <= got_count + 1;
        if (tick_results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing due, actual %0h/%0h", $time, m_tdata, m_tuser);
        end else begin
          due = tick_results_due.pop_front();
          check_field("cs_level", due.cs_level, m_tdata[0]);
          check_field("sck_level", due.sck_level, m_tdata[1]);
          check_field("mosi_level", due.mosi_level, m_tdata[2]);
          check_field("byte_taken", due.byte_taken, m_tdata[3]);
          check_field("rx_valid", due.rx_valid, m_tdata[4]);
          check_field("rx_byte", due.rx_byte, m_tdata[12:5]);
          check_field("rx_slot", due.rx_slot, m_tdata[17:13]);
          check_field("busy_res", due.busy_res, m_tdata[18]);
          check_field("status", due.status, m_tuser);
        end
        // stretches with no back-pressure alternate with random stalls
        stall_left = (((got_count >> 7) % 3) == 0) ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles without any transaction
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)
        || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic spim3_pkg::tick_t tick_of(input logic vld, input logic fn,
                                               input logic [7:0] tx,
                                               input logic lst, input logic miso);
    spim3_pkg::tick_t t;
    t.byte_valid = vld;
    t.func = fn;
    t.tx_byte = tx;
    t.last_byte = lst;
    t.miso_level = miso;
    return t;
  endfunction

  function automatic spim3_pkg::tick_t rand_tick(input int valid_pct, input int last_pct,
                                                 input int func_pct);
    return tick_of($urandom_range(0, 99) < valid_pct, $urandom_range(0, 99) < func_pct,
                   8'($urandom_range(0, 255)), $urandom_range(0, 99) < last_pct,
                   1'($urandom_range(0, 1)));
  endfunction

  task automatic add_tick(input spim3_pkg::tick_t t);
    stim_op_t op;
    op.kind = OP_TICK;
    op.tk = t;
    op.idx = spim3_pkg::REG_MSB_FIRST;
    op.val = 8'd0;
    op.gap = (cur_gap_max > 0) ? $urandom_range(0, cur_gap_max) : 0;
    stim_q.push_back(op);
  endtask

  task automatic add_op(input stim_kind_t kind, input logic [2:0] idx, input logic [7:0] val);
    stim_op_t op;
    op.kind = kind;
    op.tk = '0;
    op.idx = idx;
    op.val = val;
    op.gap = 0;
    stim_q.push_back(op);
  endtask

  task automatic add_setup(input logic msb, input logic cs, input logic mosi,
                           input logic miso, input logic [7:0] dly);
    add_op(OP_CFG, spim3_pkg::REG_MSB_FIRST, {7'd0, msb});
    add_op(OP_CFG, spim3_pkg::REG_CS_USED, {7'd0, cs});
    add_op(OP_CFG, spim3_pkg::REG_MOSI_USED, {7'd0, mosi});
    add_op(OP_CFG, spim3_pkg::REG_MISO_USED, {7'd0, miso});
    add_op(OP_CFG, spim3_pkg::REG_DELAY_TICKS, dly);
  endtask

  initial begin
    // Directed: one full frame at reset settings, then both refusals
    add_tick(tick_of(1'b1, 1'b0, 8'hFF, 1'b1, 1'b1));
    for (int i = 0; i < 18; i++) add_tick(tick_of(1'b0, 1'b1, 8'h00, 1'b0, 1'(i)));
    add_op(OP_CFG, spim3_pkg::REG_MISO_USED, 8'd0);
    add_tick(tick_of(1'b1, 1'b1, 8'h5A, 1'b1, 1'b0));
    add_op(OP_CFG, spim3_pkg::REG_MOSI_USED, 8'd0);
    add_tick(tick_of(1'b1, 1'b0, 8'hC3, 1'b0, 1'b1));
    add_op(OP_CFG, spim3_pkg::REG_MOSI_USED, 8'd1);
    add_op(OP_CFG, spim3_pkg::REG_MISO_USED, 8'd1);
    add_tick(tick_of(1'b1, 1'b1, 8'h00, 1'b1, 1'b1));

    // Random phases, each under its own register settings
    for (int p = 0; p < 10; p++) begin
      cur_gap_max = p[0] ? 9 : 0;
      if (p == 3) begin
        // long frame with zero delay and no chip select: slot index wraps
        cur_gap_max = 0;
        add_setup(1'($urandom_range(0, 1)), 1'b0, 1'b1, 1'b1, 8'd0);
        for (int i = 0; i < 520; i++) add_tick(rand_tick(100, 0, 30));
        for (int i = 0; i < 40; i++) add_tick(rand_tick(100, 100, 30));
      end else if (p == 6) begin
        // slowest delay; a frame is left mid-bit for the next phase
        add_setup(1'($urandom_range(0, 1)), 1'b1, 1'b1, 1'b1, 8'd255);
        for (int i = 0; i < 300; i++) add_tick(rand_tick(30, 35, 25));
      end else begin
        add_setup(p[0], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(1, 4)));
        for (int i = 0; i < 70; i++) begin
          add_tick(rand_tick(15, 35, 25));
          if ($urandom_range(0, 49) == 0) add_op(OP_DRAIN, spim3_pkg::REG_MSB_FIRST, 8'd0);
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (!(stim_done && (sent_count == got_count))) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tick_results_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, tick_results_due.size());
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/spim3_pkg.sv
rtl/core/spim3_step.sv
rtl/core/spi_master_mode3_bitbang_unit.sv
tb/sv/tb_spi_master_mode3_bitbang_unit.sv
